FILE: hdl/pcrc_pkg.sv
`default_nettype none
package pcrc_pkg;

  localparam int MAX_WIDTH_DEF = 64;
  localparam int CRC_OUT_W     = 64;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int BYTE_W        = 8;

  // queue depth, power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_MODE    = 3'd0,
    CFG_POLYNOMIAL    = 3'd1,
    CFG_INITIAL_VALUE = 3'd2,
    CFG_REFLECT_IN    = 3'd3,
    CFG_REFLECT_OUT   = 3'd4,
    CFG_OUTPUT_XOR    = 3'd5
  } cfg_idx_t;

  localparam logic [1:0] WM_16 = 2'd0;
  localparam logic [1:0] WM_32 = 2'd1;
  localparam logic [1:0] WM_64 = 2'd2;

  localparam logic [1:0]            RST_WIDTH_MODE  = WM_32;
  localparam logic [CFG_DATA_W-1:0] RST_POLYNOMIAL  = 64'h0000_0000_04C1_1DB7;
  localparam logic [CFG_DATA_W-1:0] RST_INIT_VALUE  = 64'h0000_0000_FFFF_FFFF;
  localparam logic                  RST_REFLECT_IN  = 1'b1;
  localparam logic                  RST_REFLECT_OUT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] RST_OUTPUT_XOR  = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has_byte;
    logic              last;
    logic              start;
  } pcrc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pcrc_qstat_t;

endpackage
`default_nettype wire

FILE: hdl/parametric_crc_engine.sv
// out_valid is registered; an item marked last is queued, then popped to set it.
// Throughput: one item per cycle while in_stall is low; the back end retires one
// queued byte a cycle, unrolling the eight polynomial steps in one pass.
// A waiting result holds the next item marked last at the queue head; input
// stalls once the 2-entry queue is full.
// Reset (rst_n low, synchronous): config registers return to their defaults,
// remainder clears and the next item starts a new message.
`default_nettype none
module parametric_crc_engine import pcrc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [BYTE_W-1:0]     in_data_byte,
  input  wire logic                  in_has_byte,
  input  wire logic                  in_last,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CRC_OUT_W-1:0]       out_crc_value,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [1:0]            width_mode_r;
  logic [CFG_DATA_W-1:0] polynomial_r, initial_value_r, output_xor_r;
  logic                  reflect_in_r, reflect_out_r;

  pcrc_qstat_t q_stat;
  pcrc_entry_t q_entry, q_head;
  logic        q_push, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r    <= RST_WIDTH_MODE;
      polynomial_r    <= RST_POLYNOMIAL;
      initial_value_r <= RST_INIT_VALUE;
      reflect_in_r    <= RST_REFLECT_IN;
      reflect_out_r   <= RST_REFLECT_OUT;
      output_xor_r    <= RST_OUTPUT_XOR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH_MODE:    width_mode_r    <= cfg_data[1:0];
        CFG_POLYNOMIAL:    polynomial_r    <= cfg_data;
        CFG_INITIAL_VALUE: initial_value_r <= cfg_data;
        CFG_REFLECT_IN:    reflect_in_r    <= cfg_data[0];
        CFG_REFLECT_OUT:   reflect_out_r   <= cfg_data[0];
        CFG_OUTPUT_XOR:    output_xor_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  pcrc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_has_byte    (in_has_byte),
    .in_last        (in_last),
    .cfg_reflect_in (reflect_in_r),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  pcrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  pcrc_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .cfg_width_mode    (width_mode_r),
    .cfg_polynomial    (polynomial_r[MAX_WIDTH-1:0]),
    .cfg_initial_value (initial_value_r[MAX_WIDTH-1:0]),
    .cfg_reflect_out   (reflect_out_r),
    .cfg_output_xor    (output_xor_r[MAX_WIDTH-1:0]),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_crc_value     (out_crc_value)
  );

endmodule
`default_nettype wire

FILE: hdl/pcrc_front.sv
`default_nettype none
module pcrc_front import pcrc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_has_byte,
  input  wire logic              in_last,
  input  wire logic              cfg_reflect_in,
  input  wire pcrc_qstat_t       q_stat,
  output logic                   q_push,
  output pcrc_entry_t            q_entry
);

  logic in_msg_r, in_msg_nxt;
  logic [BYTE_W-1:0] data_rev;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    for (int i = 0; i < BYTE_W; i++) begin
      data_rev[i] = in_data_byte[BYTE_W-1-i];
    end
  end

  always_comb begin
    q_entry.data     = cfg_reflect_in ? data_rev : in_data_byte;
    q_entry.has_byte = in_has_byte;
    q_entry.last     = in_last;
    q_entry.start    = !in_msg_r;
  end

  assign in_msg_nxt = q_push ? !in_last : in_msg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
    end else begin
      in_msg_r <= in_msg_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pcrc_queue.sv
`default_nettype none
module pcrc_queue import pcrc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire pcrc_entry_t push_entry,
  input  wire logic        pop,
  output pcrc_entry_t      head,
  output pcrc_qstat_t      stat
);

  pcrc_entry_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/pcrc_back.sv
`default_nettype none
module pcrc_back import pcrc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pcrc_qstat_t          q_stat,
  input  wire pcrc_entry_t          q_head,
  output logic                      q_pop,
  input  wire logic [1:0]           cfg_width_mode,
  input  wire logic [MAX_WIDTH-1:0] cfg_polynomial,
  input  wire logic [MAX_WIDTH-1:0] cfg_initial_value,
  input  wire logic                 cfg_reflect_out,
  input  wire logic [MAX_WIDTH-1:0] cfg_output_xor,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CRC_OUT_W-1:0]      out_crc_value
);

  localparam int SH_W  = $clog2(MAX_WIDTH);
  localparam int W32   = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
  localparam logic [SH_W-1:0] SH_16 = SH_W'(MAX_WIDTH - 16);
  localparam logic [SH_W-1:0] SH_32 = SH_W'(MAX_WIDTH - W32);
  localparam logic [SH_W-1:0] SH_64 = '0;

  logic [SH_W-1:0]      sh;
  logic [MAX_WIDTH-1:0] mask, poly_al, crc, crc_rev, res;
  logic [MAX_WIDTH-1:0] rem_r, rem_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CRC_OUT_W-1:0] out_crc_r;
  logic                 out_free;

  // remainder is worked top-aligned so the feedback tap is always the MSB
  always_comb begin
    unique case (cfg_width_mode)
      WM_16:   sh = SH_16;
      WM_32:   sh = SH_32;
      WM_64:   sh = SH_64;
      default: sh = SH_64;
    endcase
  end

  always_comb begin
    mask    = {MAX_WIDTH{1'b1}} >> sh;
    poly_al = cfg_polynomial << sh;
    crc     = (q_head.start ? cfg_initial_value : rem_r) << sh;
    if (q_head.has_byte) begin
      crc[MAX_WIDTH-1 -: BYTE_W] = crc[MAX_WIDTH-1 -: BYTE_W] ^ q_head.data;
      for (int i = 0; i < BYTE_W; i++) begin
        crc = crc[MAX_WIDTH-1] ? ((crc << 1) ^ poly_al) : (crc << 1);
      end
    end
    for (int j = 0; j < MAX_WIDTH; j++) begin
      crc_rev[j] = crc[MAX_WIDTH-1-j];
    end
    rem_nxt = crc >> sh;
    res     = (cfg_reflect_out ? crc_rev : rem_nxt) ^ (cfg_output_xor & mask);
  end

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = !q_stat.empty && (!q_head.last || out_free);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop && q_head.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        rem_r <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      out_crc_r <= CRC_OUT_W'(res);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

endmodule
`default_nettype wire

FILE: hdl/pcrc_checker.sv
`default_nettype none
module pcrc_checker import pcrc_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [CRC_OUT_W-1:0] out_crc_value,
  input wire logic                 cfg_ready
);

  a_out_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_in_open_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_crc_value))
    else $error("stalled result changed");

  // the queue only fills behind a result that is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind parametric_crc_engine pcrc_checker u_pcrc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_crc_value (out_crc_value),
  .cfg_ready     (cfg_ready)
);
`default_nettype wire
